// ===== src/krd_pkg.sv =====
// Package with the shared types, sizes and codes of the keyed record deque.
package krd_pkg;

  // Store size; the ring index wraps naturally, so this stays a power of two.
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Field widths.
  localparam int unsigned KEY_W   = 31;
  localparam int unsigned GRADE_W = 7;
  localparam int unsigned SMALL_W = 7;

  // Stream data widths, rounded up to whole bytes.
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 72;

  // Operation codes.
  localparam logic [1:0] OP_APPEND   = 2'd0;
  localparam logic [1:0] OP_POP_HEAD = 2'd1;
  localparam logic [1:0] OP_POP_TAIL = 2'd2;
  localparam logic [1:0] OP_FIND     = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // One stored record.
  typedef struct packed {
    logic [GRADE_W-1:0] mean;
    logic [GRADE_W-1:0] grade_two;
    logic [GRADE_W-1:0] grade_one;
    logic [KEY_W-1:0]   key;
  } record_t;

  // One result of an operation.
  typedef struct packed {
    logic [SMALL_W-1:0] count;
    logic [SMALL_W-1:0] position;
    logic [GRADE_W-1:0] mean;
    logic [GRADE_W-1:0] grade_two;
    logic [GRADE_W-1:0] grade_one;
    logic [KEY_W-1:0]   key;
    logic [1:0]         status;
  } result_t;

endpackage

// ===== src/keyed_record_deque.sv =====
// Top level of the keyed record deque: ring store of records with key search.
//
// The block holds up to CAPACITY records (key, two grades and a mean) in a ring
// kept in one synchronous single-port-read memory. An append, a head removal or
// a tail removal places its result in the result register on acceptance, and
// from there in the output register once that register is free; the next
// transaction is accepted only after that. A find reads one stored record per
// cycle from the head onward and stops at the first match. Its result passes
// through the registered memory read, one compare per record visited (set by
// the single read port) and the result register before it is loaded into the
// output register. One transaction is worked on at a time, but a new one is
// accepted while the previous result still waits in the output register.
// A stalled output holds the block in its finish state until it is free.
// Results carry zeros in the record and position fields unless the find
// succeeded.
module keyed_record_deque (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // op[1:0], key_in[32:2], grade_one_in[39:33], grade_two_in[46:40],
  // mean_in[53:47], zero fill [55:54]
  input  logic [krd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status[1:0], key_out[32:2], grade_one_out[39:33], grade_two_out[46:40],
  // mean_out[53:47], position[60:54], count[67:61], zero fill [71:68]
  output logic [krd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import krd_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [CNT_W-1:0] iss_q, iss_d;
  logic [CNT_W-1:0] chk_q, chk_d;
  logic             rd_vld_q, rd_vld_d;
  result_t          res_q, res_d;
  logic             out_vld_q, out_vld_d;
  result_t          out_q, out_d;

  // Record store.
  record_t          mem [CAPACITY];
  record_t          rdata_q;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  record_t          wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  // Input unpacking.
  logic [1:0]       in_op;
  logic [KEY_W-1:0] in_key;
  record_t          in_rec;
  logic             in_fire;
  logic             out_free;
  logic [CNT_W-1:0] chk_next;

  assign in_op            = s_axis_tdata[1:0];
  assign in_key           = s_axis_tdata[32:2];
  assign in_rec.key       = in_key;
  assign in_rec.grade_one = s_axis_tdata[39:33];
  assign in_rec.grade_two = s_axis_tdata[46:40];
  assign in_rec.mean      = s_axis_tdata[53:47];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign chk_next      = chk_q + CNT_W'(1);

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_q};

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Next-state logic for operations and the search walk.
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    key_d     = key_q;
    iss_d     = iss_q;
    chk_d     = chk_q;
    rd_vld_d  = 1'b0;
    res_d     = res_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    wr_en     = 1'b0;
    wr_addr   = head_q + count_q[IDX_W-1:0];
    wr_data   = in_rec;
    rd_en     = 1'b0;
    rd_addr   = head_q + iss_q[IDX_W-1:0];

    // The output register empties when the transaction is taken.
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_d        = '0;
          res_d.status = ST_OK;
          key_d        = in_key;
          state_d      = S_FINISH;
          case (in_op)
            OP_APPEND: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                res_d.status = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_POP_HEAD: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                head_d  = head_q + IDX_W'(1);
                count_d = count_q - CNT_W'(1);
              end
            end
            OP_POP_TAIL: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                count_d = count_q - CNT_W'(1);
              end
            end
            default: begin
              if (count_q == '0) begin
                res_d.status = ST_NOT_FOUND;
              end else begin
                iss_d   = '0;
                state_d = S_SEARCH;
              end
            end
          endcase
          res_d.count = SMALL_W'(count_d);
        end
      end

      S_SEARCH: begin
        // Issue one read per cycle while records remain.
        if (iss_q < count_q) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          chk_d    = iss_q;
          iss_d    = iss_q + CNT_W'(1);
        end
        // Compare the record that came back from the store.
        if (rd_vld_q) begin
          if (rdata_q.key == key_q) begin
            res_d.status    = ST_OK;
            res_d.key       = rdata_q.key;
            res_d.grade_one = rdata_q.grade_one;
            res_d.grade_two = rdata_q.grade_two;
            res_d.mean      = rdata_q.mean;
            res_d.position  = SMALL_W'(chk_next);
            rd_vld_d        = 1'b0;
            state_d         = S_FINISH;
          end else if (chk_next == count_q) begin
            res_d.status = ST_NOT_FOUND;
            rd_vld_d     = 1'b0;
            state_d      = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      iss_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      iss_q     <= iss_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    chk_q <= chk_d;
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule
